// ===== design/rce_pkg.sv =====
package rce_pkg;

    localparam int TOP_BITS    = 24;
    localparam int BOTTOM_BITS = 15;

    localparam logic [31:0] RC_TOP = 32'd1 << TOP_BITS;
    localparam logic [31:0] RC_BOT = 32'd1 << BOTTOM_BITS;

    // command codes of an input item
    localparam logic [1:0] CMD_SCALE = 2'd0;
    localparam logic [1:0] CMD_SHIFT = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] low_count;
        logic [15:0] high_count;
        logic [15:0] total_scale;
        logic [3:0]  shift_amount;
    } sym_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } code_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic shift_range;
        logic mul_lo;
        logic mul_acc;
        logic mul_range;
        logic norm_step;
        logic norm_end;
        logic flush_step;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic norm_go;
        logic norm_full;
        logic pend_valid;
        logic out_free;
        logic flush_last;
    } dp_stat_t;

endpackage

// ===== design/rce_dp.sv =====
module rce_dp
    import rce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sym_t     sym_data,
    input  dp_cmd_t  dp_cmd,
    output dp_stat_t dp_stat,
    output logic     code_valid,
    input  logic     code_stall,
    output code_t    code_data
);

    logic [31:0] low_reg,   low_next;
    logic [31:0] range_reg, range_next;
    logic [31:0] q_reg,     q_next;
    logic [15:0] rem_reg,   rem_next;
    logic [15:0] div_reg,   div_next;
    logic [4:0]  dcnt_reg,  dcnt_next;
    logic [14:0] lo_reg,    lo_next;
    logic [15:0] hi_reg,    hi_next;
    logic [3:0]  sh_reg,    sh_next;
    logic [31:0] prod_reg,  prod_next;
    logic [2:0]  cnt_reg,   cnt_next;
    logic [7:0]  pend_reg,  pend_next;
    logic        pend_v_reg, pend_v_next;
    logic        out_v_reg, out_v_next;
    code_t       out_reg,   out_next;

    logic [16:0] trial;
    logic        ge;
    logic [16:0] trial_sub;
    logic [31:0] diff;
    logic [31:0] sum;
    logic        go_raw;
    logic        clip;
    logic [31:0] clipped;
    logic        emit;
    code_t       emit_item;

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, q_reg[31]};
    assign ge        = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    assign diff = {16'd0, hi_reg} - {17'd0, lo_reg};

    // settled top byte, or an underflowing range that gets clipped
    assign sum     = low_reg + range_reg;
    assign go_raw  = (low_reg ^ sum) < RC_TOP;
    assign clip    = !go_raw && (range_reg < RC_BOT);
    assign clipped = (32'd0 - low_reg) & (RC_BOT - 32'd1);

    assign emit = (dp_cmd.norm_step && pend_v_reg) || dp_cmd.norm_end || dp_cmd.flush_step;

    always_comb
    begin
        if (dp_cmd.flush_step)
        begin
            emit_item.out_byte    = low_reg[31:24];
            emit_item.last_of_run = (cnt_reg == 3'd3);
        end
        else
        begin
            emit_item.out_byte    = pend_reg;
            emit_item.last_of_run = dp_cmd.norm_end;
        end
    end

    always_comb
    begin
        low_next    = low_reg;
        range_next  = range_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        dcnt_next   = dcnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sh_next     = sh_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        out_v_next  = out_v_reg;
        out_next    = out_reg;

        if (dp_cmd.load)
        begin
            lo_next     = sym_data.low_count;
            hi_next     = sym_data.high_count;
            sh_next     = sym_data.shift_amount;
            div_next    = (sym_data.total_scale == 16'd0) ? 16'd1 : sym_data.total_scale;
            q_next      = range_reg;
            rem_next    = '0;
            dcnt_next   = '0;
            cnt_next    = '0;
            pend_v_next = 1'b0;
        end

        if (dp_cmd.div_step)
        begin
            rem_next  = ge ? trial_sub[15:0] : trial[15:0];
            q_next    = {q_reg[30:0], ge};
            dcnt_next = dcnt_reg + 5'd1;
        end

        if (dp_cmd.shift_range)
            q_next = range_reg >> sh_reg;

        if (dp_cmd.mul_lo)
            prod_next = {17'd0, lo_reg} * q_reg;

        if (dp_cmd.mul_acc)
        begin
            low_next  = low_reg + prod_reg;
            prod_next = q_reg * diff;
        end

        if (dp_cmd.mul_range)
            range_next = prod_reg;

        if (dp_cmd.norm_step)
        begin
            pend_next   = low_reg[31:24];
            pend_v_next = 1'b1;
            low_next    = low_reg << 8;
            range_next  = (clip ? clipped : range_reg) << 8;
            cnt_next    = cnt_reg + 3'd1;
        end

        if (dp_cmd.norm_end)
            pend_v_next = 1'b0;

        if (dp_cmd.flush_step)
        begin
            low_next = low_reg << 8;
            cnt_next = cnt_reg + 3'd1;
        end

        if (emit)
        begin
            out_v_next = 1'b1;
            out_next   = emit_item;
        end
        else if (!code_stall)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= '0;
            range_reg  <= '1;
            dcnt_reg   <= '0;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            low_reg    <= low_next;
            range_reg  <= range_next;
            dcnt_reg   <= dcnt_next;
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        sh_reg   <= sh_next;
        prod_reg <= prod_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign dp_stat.div_last   = &dcnt_reg;
    assign dp_stat.norm_go    = go_raw || clip;
    assign dp_stat.norm_full  = cnt_reg[2];
    assign dp_stat.pend_valid = pend_v_reg;
    assign dp_stat.out_free   = !out_v_reg || !code_stall;
    assign dp_stat.flush_last = (cnt_reg == 3'd3);

    assign code_valid = out_v_reg;
    assign code_data  = out_reg;

endmodule

// ===== design/rce_ctrl.sv =====
module rce_ctrl
    import rce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sym_valid,
    input  logic [1:0] cmd,
    output logic     sym_stall,
    output dp_cmd_t  dp_cmd,
    input  dp_stat_t dp_stat
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_SHIFT = 8'b0000_0100,
        ST_MULA  = 8'b0000_1000,
        ST_MULB  = 8'b0001_0000,
        ST_MULC  = 8'b0010_0000,
        ST_NORM  = 8'b0100_0000,
        ST_FLUSH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign sym_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_valid)
                begin
                    dp_cmd.load = 1'b1;
                    case (cmd)
                        CMD_SCALE: state_next = ST_DIV;
                        CMD_SHIFT: state_next = ST_SHIFT;
                        CMD_FLUSH: state_next = ST_FLUSH;
                        CMD_NONE:  state_next = ST_IDLE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                dp_cmd.div_step = 1'b1;
                if (dp_stat.div_last)
                    state_next = ST_MULA;
            end
            ST_SHIFT:
            begin
                dp_cmd.shift_range = 1'b1;
                state_next         = ST_MULA;
            end
            ST_MULA:
            begin
                dp_cmd.mul_lo = 1'b1;
                state_next    = ST_MULB;
            end
            ST_MULB:
            begin
                dp_cmd.mul_acc = 1'b1;
                state_next     = ST_MULC;
            end
            ST_MULC:
            begin
                dp_cmd.mul_range = 1'b1;
                state_next       = ST_NORM;
            end
            ST_NORM:
            begin
                // one byte is held back until we know whether it closes the run
                if (dp_stat.norm_full || !dp_stat.norm_go)
                begin
                    if (!dp_stat.pend_valid)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (dp_stat.out_free)
                    begin
                        dp_cmd.norm_end = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!dp_stat.pend_valid || dp_stat.out_free)
                begin
                    dp_cmd.norm_step = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.flush_step = 1'b1;
                    if (dp_stat.flush_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/range_coder_encoder.sv =====
// Carryless range encoder with a 32-bit low and range. One symbol is worked on at a
// time; sym_stall stays high from the transfer of a symbol until its last code byte
// has been staged. An encode with a total scale first runs the bit-serial divider,
// which sets most of its time, then the multiply/accumulate states MULA, MULB and
// MULC, and then stages its code bytes. An encode with a power-of-two shift shifts
// the range in place of the divider. A flush sends four bytes on consecutive cycles.
// A stall on the code side holds the byte in the output register and pauses the run.
module range_coder_encoder
    import rce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sym_valid,
    output logic  sym_stall,
    input  sym_t  sym_data,
    output logic  code_valid,
    input  logic  code_stall,
    output code_t code_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    rce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .cmd       (sym_data.cmd),
        .sym_stall (sym_stall),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    rce_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_data   (sym_data),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data)
    );

endmodule

// ===== design/rce_checker.sv =====
module rce_props
    import rce_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  sym_valid,
    input logic  sym_stall,
    input sym_t  sym_data,
    input logic  code_valid,
    input logic  code_stall,
    input code_t code_data
);

    // a stalled code byte stays offered
    a_code_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid)
        else $error("code byte dropped while stalled");

    a_code_stable: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> $stable(code_data))
        else $error("stalled code byte changed");

    // one symbol at a time; an unused command leaves the block idle
    a_sym_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_stall && (sym_data.cmd != CMD_NONE) |=> sym_stall)
        else $error("second symbol taken while busy");

    // bytes of a run follow without gaps
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_stall && !code_data.last_of_run |=> code_valid)
        else $error("gap inside a run of code bytes");

endmodule

bind range_coder_encoder rce_props u_rce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym_valid),
    .sym_stall  (sym_stall),
    .sym_data   (sym_data),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_data  (code_data)
);

// ===== sim/rce_checker.sv =====
`timescale 1ns / 100ps

module rce_checker
    import rce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sym_valid,
    input  logic  sym_stall,
    input  sym_t  sym_data,
    input  logic  code_valid,
    input  logic  code_stall,
    input  code_t code_data,
    output int    fail_count,
    output int    pending,
    output int    bytes_checked
);

    localparam int MAX_RUN = 4;

    logic [31:0] enc_low;
    logic [31:0] enc_range;
    code_t       code_bytes_due[$];

    // Narrow the interval for one symbol and queue the code bytes it releases
    task automatic encode_symbol(input sym_t s);
        logic [31:0] r;
        logic [31:0] lo32;
        logic [31:0] hi32;
        logic [31:0] scale;
        logic [7:0]  run_bytes[MAX_RUN];
        logic        go;
        logic        done;
        code_t       c;
        int          n;
        n    = 0;
        done = 1'b0;
        lo32 = {17'd0, s.low_count};
        hi32 = {16'd0, s.high_count};
        case (s.cmd)
            CMD_SCALE, CMD_SHIFT:
            begin
                if (s.cmd == CMD_SCALE)
                begin
                    scale = (s.total_scale == 16'd0) ? 32'd1 : {16'd0, s.total_scale};
                    r = enc_range / scale;
                end
                else
                begin
                    r = enc_range >> s.shift_amount;
                end
                enc_low   = enc_low + lo32 * r;
                enc_range = r * (hi32 - lo32);
                // at most four bytes, even if the range has collapsed
                while (n < MAX_RUN && !done)
                begin
                    go = ((enc_low ^ (enc_low + enc_range)) < RC_TOP);
                    if (!go && enc_range < RC_BOT)
                    begin
                        enc_range = (32'd0 - enc_low) & (RC_BOT - 32'd1);
                        go = 1'b1;
                    end
                    if (go)
                    begin
                        run_bytes[n] = enc_low[31:24];
                        n++;
                        enc_range = enc_range << 8;
                        enc_low   = enc_low << 8;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            CMD_FLUSH:
            begin
                for (int i = 0; i < MAX_RUN; i++)
                begin
                    run_bytes[i] = enc_low[31:24];
                    enc_low = enc_low << 8;
                end
                n = MAX_RUN;
            end
            default:
            begin
                n = 0;
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            c.out_byte    = run_bytes[i];
            c.last_of_run = (i == n - 1);
            code_bytes_due.push_back(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        code_t want;
        if (!rst_n)
        begin
            enc_low   = '0;
            enc_range = '1;
            code_bytes_due.delete();
            fail_count    = 0;
            bytes_checked = 0;
        end
        else
        begin
            if (sym_valid && !sym_stall)
                encode_symbol(sym_data);
            if (code_valid && !code_stall)
            begin
                bytes_checked++;
                if (code_bytes_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: code byte with none due: expected nothing, got byte %h last %b",
                             $time, code_data.out_byte, code_data.last_of_run);
                end
                else
                begin
                    want = code_bytes_due.pop_front();
                    if (want.out_byte !== code_data.out_byte)
                    begin
                        fail_count++;
                        $display("%0t: out_byte expected %h got %h",
                                 $time, want.out_byte, code_data.out_byte);
                    end
                    if (want.last_of_run !== code_data.last_of_run)
                    begin
                        fail_count++;
                        $display("%0t: last_of_run expected %b got %b",
                                 $time, want.last_of_run, code_data.last_of_run);
                    end
                end
            end
        end
        pending = code_bytes_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rce_pkg::*;

    localparam int RANDOM_SYMS = 330;

    logic  clk;
    logic  rst_n      = 1'b0;
    logic  sym_valid  = 1'b0;
    logic  sym_stall;
    sym_t  sym_data   = '0;
    logic  code_valid;
    logic  code_stall = 1'b0;
    code_t code_data;
    logic  quiet      = 1'b0;

    int fail_count;
    int pending;
    int bytes_checked;
    int n_scale = 0;
    int n_shift = 0;
    int n_flush = 0;
    int n_none  = 0;

    range_coder_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_data   (sym_data),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data)
    );

    rce_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym_valid     (sym_valid),
        .sym_stall     (sym_stall),
        .sym_data      (sym_data),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code_data     (code_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        code_stall <= !quiet && ($urandom_range(99) < 7);

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic sym_t mk(input logic [1:0] cmd, input int lo, input int hi,
                                input int sc, input int sh);
        sym_t s;
        s.cmd          = cmd;
        s.low_count    = 15'(lo);
        s.high_count   = 16'(hi);
        s.total_scale  = 16'(sc);
        s.shift_amount = 4'(sh);
        return s;
    endfunction

    function automatic sym_t random_sym();
        sym_t s;
        int   pick;
        int   tot;
        int   hi;
        int   lo;
        pick           = $urandom_range(99);
        s.cmd          = CMD_SCALE;
        s.low_count    = 15'($urandom);
        s.high_count   = 16'($urandom);
        s.total_scale  = 16'($urandom);
        s.shift_amount = 4'($urandom);
        if (pick < 84)
        begin
            if (pick < 42)
            begin
                tot = ($urandom_range(3) == 0) ? $urandom_range(16, 1)
                                               : $urandom_range(32768, 1);
                s.total_scale = 16'(tot);
            end
            else
            begin
                s.cmd = CMD_SHIFT;
                tot   = 1 << s.shift_amount;
            end
            hi = $urandom_range(tot, 1);
            // narrow symbols drive the range down to the clipping path
            lo = ($urandom_range(2) == 0) ? hi - 1 : $urandom_range(hi - 1, 0);
            s.low_count  = 15'(lo);
            s.high_count = 16'(hi);
        end
        else if (pick < 91)
        begin
            s.cmd = CMD_FLUSH;
        end
        else if (pick < 95)
        begin
            s.cmd = CMD_NONE;
        end
        else
        begin
            // malformed counts; an empty symbol would pin the range at zero
            s.cmd         = ($urandom_range(1) == 0) ? CMD_SCALE : CMD_SHIFT;
            s.total_scale = 16'($urandom_range(32768, 1));
            if (s.high_count == {1'b0, s.low_count})
                s.high_count = s.high_count + 16'd1;
        end
        return s;
    endfunction

    task automatic send_sym(input sym_t s);
        while (!quiet && $urandom_range(99) < 7)
        begin
            sym_valid <= 1'b0;
            @(posedge clk);
        end
        sym_valid <= 1'b1;
        sym_data  <= s;
        @(posedge clk);
        while (sym_stall)
            @(posedge clk);
        case (s.cmd)
            CMD_SCALE: n_scale++;
            CMD_SHIFT: n_shift++;
            CMD_FLUSH: n_flush++;
            default:   n_none++;
        endcase
    endtask

    initial
    begin : stimulus
        sym_t s;
        int   syms_left;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sym(mk(CMD_SCALE, 0, 1, 32768, 0));
        send_sym(mk(CMD_SCALE, 32767, 32768, 32768, 15));
        send_sym(mk(CMD_SCALE, 0, 1, 0, 0));            // zero scale taken as one
        send_sym(mk(CMD_SCALE, 0, 1, 1, 0));
        send_sym(mk(CMD_SHIFT, 0, 1, 0, 0));
        send_sym(mk(CMD_SHIFT, 0, 32768, 0, 15));       // full share, no bytes
        send_sym(mk(CMD_SHIFT, 32767, 32768, 65535, 15));
        send_sym(mk(CMD_SHIFT, 0, 1, 0, 15));
        send_sym(mk(CMD_SHIFT, 0, 1, 0, 15));
        send_sym(mk(CMD_SHIFT, 1, 2, 0, 15));
        send_sym(mk(CMD_SCALE, 5, 3, 10, 0));           // low above high
        send_sym(mk(CMD_SCALE, 0, 65535, 7, 0));        // high past the total
        send_sym(mk(CMD_SHIFT, 32767, 65535, 65535, 15));
        send_sym(mk(CMD_NONE, 32767, 65535, 65535, 15));
        send_sym(mk(CMD_SCALE, 1, 2, 32768, 0));
        send_sym(mk(CMD_FLUSH, 0, 0, 0, 0));
        send_sym(mk(CMD_FLUSH, 32767, 65535, 65535, 15));

        syms_left = RANDOM_SYMS;
        while (syms_left > 0)
        begin
            quiet <= (syms_left < 200 && syms_left > 120);
            s = random_sym();
            send_sym(s);
            if (s.cmd != CMD_NONE)
                syms_left--;
        end
        quiet <= 1'b0;

        // empty symbol last: the range sticks at zero, every encode hits the byte cap
        send_sym(mk(CMD_SCALE, 100, 100, 200, 0));
        send_sym(mk(CMD_SHIFT, 7, 9, 0, 3));
        send_sym(mk(CMD_FLUSH, 0, 0, 0, 0));
        sym_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);

        $display("Symbols sent: %0d scale, %0d shift, %0d flush, %0d unused command",
                 n_scale, n_shift, n_flush, n_none);
        $display("Code bytes compared: %0d", bytes_checked);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
